// File: design/sapc_pkg.sv
// shared types and constants for the stepper axis position control block
package sapc_pkg;

   localparam int POS_BITS       = 16;
   localparam int KIND_BITS      = 3;
   localparam int STATUS_BITS    = 2;
   localparam int CSR_INDEX_BITS = 2;

   typedef logic signed [POS_BITS-1:0] pos_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_TICK = 3'd0,
      KIND_GOTO = 3'd1,
      KIND_JOG  = 3'd2,
      KIND_STOP = 3'd3,
      KIND_ZERO = 3'd4
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_UNDER_LOW  = 2'd1,
      STATUS_OVER_HIGH  = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LOWER_LIMIT = 2'd0,
      CSR_UPPER_LIMIT = 2'd1
   } csr_index_type;

   // most negative and most positive position values
   localparam pos_type POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};
   localparam pos_type POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};

endpackage

// File: design/stepper_axis_position_control.sv
// Stepper axis position control: one request beat in, one response beat out per item. Every
// item is registered on entry, evaluated against the axis state by a single stage of compare
// and increment logic, and then captured in the response register, so the block takes
// one item per clock for as long as the response side keeps up. When the response is stalled,
// one more item is held in the entry register before req_stall rises. The two travel limits
// are written through the csr port (index 0 lower limit, index 1 upper limit, other indexes
// ignored); csr_ready is always high. Write them only while no item is in flight.
module stepper_axis_position_control (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [sapc_pkg::KIND_BITS-1:0]     req_kind,
   input  logic signed [sapc_pkg::POS_BITS-1:0] req_target_position,
   input  logic signed [sapc_pkg::POS_BITS-1:0] req_jog_speed,
   input  logic                               req_stop_request,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_step_pulse,
   output logic signed [sapc_pkg::POS_BITS-1:0] rsp_position,
   output logic                               rsp_moving_down,
   output logic                               rsp_driver_enabled,
   output logic                               rsp_running,
   output logic                               rsp_soft_estop,
   output logic [sapc_pkg::STATUS_BITS-1:0]   rsp_goto_status,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sapc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic signed [sapc_pkg::POS_BITS-1:0] csr_data
);
   import sapc_pkg::*;

   // entry register
   logic                 in_valid_ff, in_valid_in;
   logic [KIND_BITS-1:0] kind_ff;
   pos_type              target_ff;
   pos_type              speed_ff;
   logic                 stop_ff;

   // axis state
   pos_type lower_ff, upper_ff;
   pos_type position_ff, position_in;
   pos_type goal_ff, goal_in;
   logic    down_ff, down_in;
   logic    active_ff, active_in;
   logic    enable_ff, enable_in;
   logic    estop_ff, estop_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       pulse_ff, pulse_in;
   status_type status_ff, status_in;

   logic    out_free, fire, in_load;
   pos_type step_pos;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign in_load   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = in_load || (in_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   // one step toward the goal, wrapping
   assign step_pos = down_ff ? position_ff + pos_type'(1) : position_ff - pos_type'(1);

   always_comb begin
      position_in = position_ff;
      goal_in     = goal_ff;
      down_in     = down_ff;
      active_in   = active_ff;
      enable_in   = enable_ff;
      estop_in    = estop_ff;
      pulse_in    = 1'b0;
      status_in   = STATUS_OK;
      case (kind_ff)
         KIND_TICK: begin
            if (active_ff) begin
               if (position_ff > lower_ff || position_ff < upper_ff) begin
                  active_in = 1'b0;
                  estop_in  = 1'b1;
               end else if (stop_ff) begin
                  active_in = 1'b0;
                  enable_in = 1'b0;
               end else begin
                  pulse_in    = 1'b1;
                  position_in = step_pos;
                  if (down_ff ? (step_pos >= goal_ff) : (step_pos <= goal_ff)) begin
                     active_in = 1'b0;
                     enable_in = 1'b0;
                  end
               end
            end
         end
         KIND_GOTO: begin
            if (target_ff < lower_ff && target_ff > upper_ff) begin
               goal_in   = target_ff;
               down_in   = target_ff > position_ff;
               enable_in = 1'b1;
               active_in = 1'b1;
            end else begin
               status_in = (target_ff > lower_ff) ? STATUS_UNDER_LOW : STATUS_OVER_HIGH;
            end
         end
         KIND_JOG: begin
            down_in   = speed_ff > pos_type'(0);
            goal_in   = (speed_ff > pos_type'(0)) ? lower_ff : upper_ff;
            enable_in = 1'b1;
            active_in = 1'b1;
         end
         KIND_STOP: begin
            active_in = 1'b0;
            enable_in = 1'b0;
         end
         KIND_ZERO: begin
            position_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lower_ff     <= POS_MIN;
         upper_ff     <= POS_MAX;
         position_ff  <= '0;
         goal_ff      <= '0;
         down_ff      <= 1'b0;
         active_ff    <= 1'b0;
         enable_ff    <= 1'b0;
         estop_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LOWER_LIMIT: lower_ff <= csr_data;
               CSR_UPPER_LIMIT: upper_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (fire) begin
            position_ff <= position_in;
            goal_ff     <= goal_in;
            down_ff     <= down_in;
            active_ff   <= active_in;
            enable_ff   <= enable_in;
            estop_ff    <= estop_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_load) begin
         kind_ff   <= req_kind;
         target_ff <= req_target_position;
         speed_ff  <= req_jog_speed;
         stop_ff   <= req_stop_request;
      end
      if (fire) begin
         pulse_ff  <= pulse_in;
         status_ff <= status_in;
      end
   end

   // state after the item is the response payload, held while stalled
   logic    snap_valid_ff;
   pos_type rsp_pos_ff;
   logic    rsp_down_ff, rsp_enable_ff, rsp_active_ff, rsp_estop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (fire) begin
         snap_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_pos_ff    <= position_in;
         rsp_down_ff   <= down_in;
         rsp_enable_ff <= enable_in;
         rsp_active_ff <= active_in;
         rsp_estop_ff  <= estop_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff && snap_valid_ff;
   assign rsp_step_pulse     = pulse_ff;
   assign rsp_position       = rsp_pos_ff;
   assign rsp_moving_down    = rsp_down_ff;
   assign rsp_driver_enabled = rsp_enable_ff;
   assign rsp_running        = rsp_active_ff;
   assign rsp_soft_estop     = rsp_estop_ff;
   assign rsp_goto_status    = status_ff;

endmodule

// File: design/sapc_checker.sv
// port-level checks for the stepper axis position control block, with its bind
module sapc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_step_pulse,
   input logic signed [sapc_pkg::POS_BITS-1:0] rsp_position,
   input logic                                 rsp_driver_enabled,
   input logic                                 rsp_running,
   input logic                                 rsp_soft_estop,
   input logic [sapc_pkg::STATUS_BITS-1:0]     rsp_goto_status
);
   import sapc_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position)
         && $stable(rsp_goto_status))
      else $error("stalled response beat changed");

   // no response right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // the estop latch never clears once shown
   a_estop_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_soft_estop |=> !rsp_valid || rsp_soft_estop)
      else $error("soft estop cleared without reset");

   // a step either keeps moving with the driver on or halts with it off
   a_step_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_pulse |->
         (rsp_running == rsp_driver_enabled) && (rsp_goto_status == STATUS_OK))
      else $error("step beat with inconsistent run and enable flags");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_goto_status == STATUS_OK || rsp_goto_status == STATUS_UNDER_LOW
         || rsp_goto_status == STATUS_OVER_HIGH)
      else $error("unknown goto status");

endmodule

bind stepper_axis_position_control sapc_checker u_sapc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_step_pulse     (rsp_step_pulse),
   .rsp_position       (rsp_position),
   .rsp_driver_enabled (rsp_driver_enabled),
   .rsp_running        (rsp_running),
   .rsp_soft_estop     (rsp_soft_estop),
   .rsp_goto_status    (rsp_goto_status)
);
